[rtl/cofr_pkg.sv]
`timescale 1ns / 1ps

package cofr_pkg;

  localparam int DEFAULT_MAX_RADIUS = 1023;
  localparam int OUT_W = 17;

  typedef enum logic [3:0] {
    S_READY   = 4'b0001,
    S_BUILD_A = 4'b0010,
    S_BUILD_B = 4'b0100,
    S_FETCH   = 4'b1000
  } state_t;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // center plus or minus a magnitude, wrapped to the result width
  function automatic logic [OUT_W-1:0] offset_coord(input logic signed [15:0] c,
                                                    input logic [OUT_W-1:0] mag,
                                                    input logic neg);
    logic [OUT_W-1:0] base;
    base = {c[15], c};
    offset_coord = neg ? (base - mag) : (base + mag);
  endfunction

endpackage

[rtl/circle_outline_and_fill_raster_core.sv]
`timescale 1ns / 1ps

// Circle rasterizer: outline pixels or filled-disc spans, one result per request.
// Input channel: a request is taken when start is high and busy is low. in_op
// selects a new circle (loads center, radius, thickness, fill flag, color) or
// an advance (asks for the next pixel or span of the running circle).
// Result channel: out_valid strobes for one cycle, in the cycle after an advance
// request that finds a circle running; out_last marks the final result. The
// receiver cannot stall; every strobed result must be taken.
// Throughput: advance requests are taken every cycle while busy is low, one
// result each. An outline start is taken with no busy time. A fill start
// builds the per-row half-width table with the shared midpoint step unit, two
// table writes per step on the single write port, then prefetches row 0 in
// S_FETCH; busy stays high until that prefetch is done.
// An empty circle (radius or thickness zero) and an advance with no circle
// running give no result. A new start abandons a running outline or span walk.
// Reset clears the control state; the table needs no clearing since every row
// read is written by the build that precedes it.
module circle_outline_and_fill_raster_core #(
  parameter int MAX_RADIUS = cofr_pkg::DEFAULT_MAX_RADIUS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic [9:0]         in_radius,
  input  logic [13:0]        in_thickness_q4,
  input  logic               in_fill_mode,
  input  logic [31:0]        in_color,
  output logic               out_valid,
  output logic signed [16:0] out_span_x_start,
  output logic signed [16:0] out_span_x_end,
  output logic signed [16:0] out_pixel_y,
  output logic [31:0]        out_pixel_color,
  output logic               out_last
);

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int EW = RW + 3;
  localparam int LW = (RW > 10) ? RW : 10;
  localparam int OW = cofr_pkg::OUT_W;
  localparam logic [LW-1:0] MAXR_L = LW'(MAX_RADIUS);

  cofr_pkg::state_t state_r, state_nxt;

  logic               active_r, active_nxt;
  logic               mode_fill_r, mode_fill_nxt;
  logic signed [15:0] cx_r, cx_nxt;
  logic signed [15:0] cy_r, cy_nxt;
  logic [31:0]        color_r, color_nxt;
  logic [RW-1:0]      ring_r, ring_nxt;
  logic [RW-1:0]      stop_r, stop_nxt;
  logic [RW-1:0]      x_r, x_nxt;
  logic [RW-1:0]      y_r, y_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [2:0]         slot_r, slot_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic               lower_r, lower_nxt;

  logic               ov_r, ov_nxt;
  logic [OW-1:0]      ox0_r, ox0_nxt;
  logic [OW-1:0]      ox1_r, ox1_nxt;
  logic [OW-1:0]      oy_r, oy_nxt;
  logic [31:0]        ocol_r, ocol_nxt;
  logic               olast_r, olast_nxt;

  logic [RW-1:0]      hw_mem [0:MAX_RADIUS];
  logic [RW-1:0]      rd_q;
  logic               mem_we;
  logic [RW-1:0]      mem_wa;
  logic [RW-1:0]      mem_wd;

  // start request decode
  logic [LW-1:0] rad_l, r_sat, rings_l, rings_c, stop_l;
  logic          empty_c;

  always_comb begin
    rad_l   = LW'(in_radius);
    r_sat   = (rad_l > MAXR_L) ? MAXR_L : rad_l;
    rings_l = LW'(in_thickness_q4[13:4]);
    rings_c = (rings_l == '0) ? LW'(1) : rings_l;
    stop_l  = (rings_c < r_sat) ? (r_sat - rings_c + LW'(1)) : LW'(1);
    empty_c = (in_radius == '0) || (in_thickness_q4 == '0);
  end

  // shared midpoint step unit
  logic [RW-1:0]      wy1, wx1;
  logic signed [EW:0] we1, we2, wdiff;
  logic               wtake, wexit;

  always_comb begin
    wy1   = y_r + RW'(1);
    we1   = {err_r[EW-1], err_r} + $signed({{(EW - RW){1'b0}}, wy1, 1'b1});
    wdiff = we1 - $signed({{(EW + 1 - RW){1'b0}}, x_r});
    wtake = !wdiff[EW];
    wx1   = wtake ? (x_r - RW'(1)) : x_r;
    we2   = wtake ? (we1 + (EW + 1)'(1) - $signed({{(EW - RW){1'b0}}, wx1, 1'b0})) : we1;
    wexit = wx1 < wy1;
  end

  // outline octant selection
  logic [RW-1:0] mag_x, mag_y;
  logic          neg_x, neg_y;

  always_comb begin
    case (slot_r)
      3'd0: begin mag_x = x_r; neg_x = 1'b0; mag_y = y_r; neg_y = 1'b0; end
      3'd1: begin mag_x = y_r; neg_x = 1'b0; mag_y = x_r; neg_y = 1'b0; end
      3'd2: begin mag_x = y_r; neg_x = 1'b1; mag_y = x_r; neg_y = 1'b0; end
      3'd3: begin mag_x = x_r; neg_x = 1'b1; mag_y = y_r; neg_y = 1'b0; end
      3'd4: begin mag_x = x_r; neg_x = 1'b1; mag_y = y_r; neg_y = 1'b1; end
      3'd5: begin mag_x = y_r; neg_x = 1'b1; mag_y = x_r; neg_y = 1'b1; end
      3'd6: begin mag_x = y_r; neg_x = 1'b0; mag_y = x_r; neg_y = 1'b1; end
      default: begin mag_x = x_r; neg_x = 1'b0; mag_y = y_r; neg_y = 1'b1; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    mode_fill_nxt = mode_fill_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    color_nxt     = color_r;
    ring_nxt      = ring_r;
    stop_nxt      = stop_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    err_nxt       = err_r;
    slot_nxt      = slot_r;
    row_nxt       = row_r;
    lower_nxt     = lower_r;
    ov_nxt        = 1'b0;
    ox0_nxt       = ox0_r;
    ox1_nxt       = ox1_r;
    oy_nxt        = oy_r;
    ocol_nxt      = ocol_r;
    olast_nxt     = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = x_r;
    mem_wd        = y_r;

    case (state_r)
      cofr_pkg::S_READY: begin
        if (start) begin
          if (in_op == cofr_pkg::OP_START) begin
            cx_nxt        = in_center_x;
            cy_nxt        = in_center_y;
            color_nxt     = in_color;
            mode_fill_nxt = in_fill_mode;
            ring_nxt      = r_sat[RW-1:0];
            stop_nxt      = stop_l[RW-1:0];
            slot_nxt      = '0;
            row_nxt       = '0;
            lower_nxt     = 1'b0;
            active_nxt    = !empty_c;
            if (!empty_c) begin
              x_nxt   = r_sat[RW-1:0];
              y_nxt   = '0;
              err_nxt = '0;
              if (in_fill_mode) begin
                state_nxt = cofr_pkg::S_BUILD_A;
              end
            end
          end else if (active_r) begin
            ov_nxt   = 1'b1;
            ocol_nxt = color_r;
            if (mode_fill_r) begin
              ox0_nxt = cofr_pkg::offset_coord(cx_r, OW'(rd_q), 1'b1);
              ox1_nxt = cofr_pkg::offset_coord(cx_r, OW'(rd_q), 1'b0);
              oy_nxt  = cofr_pkg::offset_coord(cy_r, OW'(row_r), lower_r);
              if (!lower_r && (row_r != '0)) begin
                lower_nxt = 1'b1;
              end else if (row_r >= ring_r) begin
                active_nxt = 1'b0;
                olast_nxt  = 1'b1;
              end else begin
                row_nxt   = row_r + RW'(1);
                lower_nxt = 1'b0;
              end
            end else begin
              ox0_nxt  = cofr_pkg::offset_coord(cx_r, OW'(mag_x), neg_x);
              ox1_nxt  = cofr_pkg::offset_coord(cx_r, OW'(mag_x), neg_x);
              oy_nxt   = cofr_pkg::offset_coord(cy_r, OW'(mag_y), neg_y);
              slot_nxt = slot_r + 3'd1;
              if (slot_r == 3'd7) begin
                x_nxt   = wx1;
                y_nxt   = wy1;
                err_nxt = we2[EW-1:0];
                if (wexit) begin
                  if (ring_r > stop_r) begin
                    ring_nxt = ring_r - RW'(1);
                    x_nxt    = ring_r - RW'(1);
                    y_nxt    = '0;
                    err_nxt  = '0;
                  end else begin
                    active_nxt = 1'b0;
                    olast_nxt  = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      cofr_pkg::S_BUILD_A: begin
        mem_we    = 1'b1;
        mem_wa    = x_r;
        mem_wd    = y_r;
        state_nxt = cofr_pkg::S_BUILD_B;
      end
      cofr_pkg::S_BUILD_B: begin
        mem_we    = 1'b1;
        mem_wa    = y_r;
        mem_wd    = x_r;
        x_nxt     = wx1;
        y_nxt     = wy1;
        err_nxt   = we2[EW-1:0];
        state_nxt = wexit ? cofr_pkg::S_FETCH : cofr_pkg::S_BUILD_A;
      end
      cofr_pkg::S_FETCH: begin
        state_nxt = cofr_pkg::S_READY;
      end
      default: begin
        state_nxt = cofr_pkg::S_READY;
      end
    endcase
  end

  // half-width table: rows written in walk order so the widest column wins
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hw_mem[mem_wa] <= mem_wd;
    end
    rd_q <= hw_mem[row_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cofr_pkg::S_READY;
      active_r    <= 1'b0;
      mode_fill_r <= 1'b0;
      slot_r      <= '0;
      row_r       <= '0;
      lower_r     <= 1'b0;
      ov_r        <= 1'b0;
      olast_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      mode_fill_r <= mode_fill_nxt;
      slot_r      <= slot_nxt;
      row_r       <= row_nxt;
      lower_r     <= lower_nxt;
      ov_r        <= ov_nxt;
      olast_r     <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    color_r <= color_nxt;
    ring_r  <= ring_nxt;
    stop_r  <= stop_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    err_r   <= err_nxt;
    ox0_r   <= ox0_nxt;
    ox1_r   <= ox1_nxt;
    oy_r    <= oy_nxt;
    ocol_r  <= ocol_nxt;
  end

  assign busy             = (state_r != cofr_pkg::S_READY);
  assign out_valid        = ov_r;
  assign out_span_x_start = $signed(ox0_r);
  assign out_span_x_end   = $signed(ox1_r);
  assign out_pixel_y      = $signed(oy_r);
  assign out_pixel_color  = ocol_r;
  assign out_last         = olast_r;

  a_out_follows_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $past(start && !busy && (in_op == cofr_pkg::OP_ADVANCE)))
    else $error("result without an advance request");

  a_last_ends_circle: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && olast_r) |-> !active_r)
    else $error("circle still running after last result");

  a_outline_octant: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cofr_pkg::S_READY) && active_r && !mode_fill_r) |-> (x_r >= y_r))
    else $error("outline walk left its octant");

  a_fetch_to_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cofr_pkg::S_FETCH) |=> (state_r == cofr_pkg::S_READY))
    else $error("prefetch did not return to ready");

  a_build_active: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cofr_pkg::S_BUILD_A) || (state_r == cofr_pkg::S_BUILD_B))
      |-> (active_r && mode_fill_r))
    else $error("table build without a running fill");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int MAXR = cofr_pkg::DEFAULT_MAX_RADIUS;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1850;

  typedef struct {
    logic signed [16:0] x_lo;
    logic signed [16:0] x_hi;
    logic signed [16:0] row;
    logic [31:0]        color;
    logic               last;
  } span_t;

  class raster_scoreboard;
    int unsigned half_width[0:MAXR];
    bit running, fill, lower;
    int cx0, cy0, ring_r, ring_end, wx, wy, werr, slot, row;
    logic [31:0] tint;
    span_t pending[$];
    int n_requests, n_outline, n_fill, n_results, n_closed, n_bad;

    function void begin_walk(int r);
      wx = r;
      wy = 0;
      werr = 0;
    endfunction

    function void step_walk();
      wy++;
      werr += 1 + 2 * wy;
      if (2 * (werr - wx) + 1 > 0) begin
        wx--;
        werr += 1 - 2 * wx;
      end
    endfunction

    function void raise_row(int r, int w);
      if (r >= 0 && r <= MAXR && w > half_width[r]) half_width[r] = w;
    endfunction

    function void take_request(logic op, logic signed [15:0] cx, logic signed [15:0] cy,
                               logic [9:0] rad, logic [13:0] th, logic fm,
                               logic [31:0] col);
      int r, rings, w, px, py, x0;
      bit fin;
      span_t s;
      n_requests++;
      if (op == cofr_pkg::OP_START) begin
        r = rad;
        if (r > MAXR) r = MAXR;
        rings = th >> 4;
        if (rings < 1) rings = 1;
        cx0 = cx;
        cy0 = cy;
        tint = col;
        fill = fm;
        ring_r = r;
        ring_end = (rings < r) ? r - rings + 1 : 1;
        slot = 0;
        row = 0;
        lower = 0;
        running = (r != 0) && (th != 0);
        if (running && fill) begin
          n_fill++;
          for (int i = 0; i <= r; i++) half_width[i] = 0;
          begin_walk(r);
          while (wx >= wy) begin
            raise_row(wy, wx);
            raise_row(wx, wy);
            step_walk();
          end
        end else if (running) begin
          n_outline++;
          begin_walk(r);
        end
        return;
      end
      if (!running) return;
      fin = 0;
      if (fill) begin
        w = half_width[row & MAXR];
        x0 = cx0 - w;
        s.x_lo = x0[16:0];
        x0 = cx0 + w;
        s.x_hi = x0[16:0];
        py = lower ? cy0 - row : cy0 + row;
        if (!lower && row > 0) begin
          lower = 1;
        end else if (row >= ring_r) begin
          running = 0;
          fin = 1;
        end else begin
          row++;
          lower = 0;
        end
      end else begin
        case (slot)
          0: begin px = wx;  py = wy;  end
          1: begin px = wy;  py = wx;  end
          2: begin px = -wy; py = wx;  end
          3: begin px = -wx; py = wy;  end
          4: begin px = -wx; py = -wy; end
          5: begin px = -wy; py = -wx; end
          6: begin px = wy;  py = -wx; end
          default: begin px = wx; py = -wy; end
        endcase
        x0 = cx0 + px;
        s.x_lo = x0[16:0];
        s.x_hi = x0[16:0];
        py = cy0 + py;
        slot++;
        if (slot >= 8) begin
          slot = 0;
          step_walk();
          if (wx < wy) begin
            if (ring_r > ring_end) begin
              ring_r--;
              begin_walk(ring_r);
            end else begin
              running = 0;
              fin = 1;
            end
          end
        end
      end
      s.row = py[16:0];
      s.color = tint;
      s.last = fin;
      pending.push_back(s);
    endfunction

    function void match_result(logic signed [16:0] xs, logic signed [16:0] xe,
                               logic signed [16:0] y, logic [31:0] col, logic lst);
      span_t e;
      n_results++;
      if (lst === 1'b1) n_closed++;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: x0=%0d x1=%0d y=%0d color=%h last=%0d",
                   xs, xe, y, col, lst);
        return;
      end
      e = pending.pop_front();
      if (xs !== e.x_lo || xe !== e.x_hi || y !== e.row || col !== e.color ||
          lst !== e.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"mismatch: exp x0=%0d x1=%0d y=%0d color=%h last=%0d",
                    " / got x0=%0d x1=%0d y=%0d color=%h last=%0d"},
                   e.x_lo, e.x_hi, e.row, e.color, e.last, xs, xe, y, col, lst);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = cofr_pkg::OP_ADVANCE;
  logic signed [15:0] in_center_x = '0;
  logic signed [15:0] in_center_y = '0;
  logic [9:0]         in_radius = '0;
  logic [13:0]        in_thickness_q4 = '0;
  logic               in_fill_mode = 1'b0;
  logic [31:0]        in_color = '0;
  logic               out_valid;
  logic signed [16:0] out_span_x_start;
  logic signed [16:0] out_span_x_end;
  logic signed [16:0] out_pixel_y;
  logic [31:0]        out_pixel_color;
  logic               out_last;

  raster_scoreboard sb = new;
  int gap_pct = 0;
  int idle_cycles = 0;

  circle_outline_and_fill_raster_core u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.take_request(in_op, in_center_x, in_center_y, in_radius, in_thickness_q4,
                        in_fill_mode, in_color);
      if (out_valid)
        sb.match_result(out_span_x_start, out_span_x_end, out_pixel_y, out_pixel_color,
                        out_last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int outline_count(int r, int th);
    int rings, stop, total, x, y, e;
    rings = th >> 4;
    if (rings < 1) rings = 1;
    stop = (rings < r) ? r - rings + 1 : 1;
    total = 0;
    for (int rr = r; rr >= stop; rr--) begin
      x = rr;
      y = 0;
      e = 0;
      while (x >= y) begin
        total += 8;
        y++;
        e += 1 + 2 * y;
        if (2 * (e - x) + 1 > 0) begin
          x--;
          e += 1 - 2 * x;
        end
      end
    end
    return total;
  endfunction

  function automatic int pick_thickness();
    case ($urandom_range(0, 2))
      0: return $urandom_range(1, 15);
      1: return $urandom_range(16, 80);
      default: return $urandom_range(1, 16383);
    endcase
  endfunction

  task automatic send(input logic op, input int cx, input int cy, input int r, input int th,
                      input logic fm, input logic [31:0] col);
    start <= 1'b1;
    in_op <= op;
    in_center_x <= cx[15:0];
    in_center_y <= cy[15:0];
    in_radius <= r[9:0];
    in_thickness_q4 <= th[13:0];
    in_fill_mode <= fm;
    in_color <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic advance(input int n);
    repeat (n)
      send(cofr_pkg::OP_ADVANCE, $urandom, $urandom, $urandom_range(0, 1023),
           $urandom_range(0, 16383), $urandom_range(0, 1), $urandom);
  endtask

  initial begin
    int items, kind, r, th, n_adv, extra;
    logic fm;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle advances, empty circles, tiny circles at the coordinate
    // extremes, then large circles abandoned by a new start
    advance(1);
    send(cofr_pkg::OP_START, $urandom, $urandom, 0, 16, 1'b0, $urandom);
    advance(1);
    send(cofr_pkg::OP_START, $urandom, $urandom, 5, 0, 1'b1, $urandom);
    advance(1);
    send(cofr_pkg::OP_START, 32767, -32768, 1, 16, 1'b0, 32'hffff_ffff);
    advance(8);
    send(cofr_pkg::OP_START, -32768, 32767, 1, 1, 1'b1, 32'h0);
    advance(3);
    send(cofr_pkg::OP_START, 32767, 32767, 1023, 16383, 1'b1, $urandom);
    advance(2);
    send(cofr_pkg::OP_START, -32768, -32768, 1023, 16383, 1'b0, $urandom);
    advance(2);

    items = 0;
    while (items < RANDOM_ITEMS) begin
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      kind = $urandom_range(0, 99);
      extra = 0;
      if (kind < 35) begin
        fm = 1'b0;
        r = $urandom_range(1, 6);
        th = pick_thickness();
        n_adv = outline_count(r, th);
      end else if (kind < 65) begin
        fm = 1'b1;
        r = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 15);
        th = pick_thickness();
        n_adv = 2 * r + 1;
      end else if (kind < 80) begin
        fm = $urandom_range(0, 1);
        r = $urandom_range(0, 1023);
        th = $urandom_range(0, 16383);
        n_adv = $urandom_range(0, 30);
      end else if (kind < 90) begin
        fm = 1'b0;
        r = $urandom_range(7, 20);
        th = $urandom_range(1, 31);
        n_adv = outline_count(r, th);
      end else begin
        fm = $urandom_range(0, 1);
        if ($urandom_range(0, 1)) begin
          r = 0;
          th = $urandom_range(0, 16383);
        end else begin
          r = $urandom_range(0, 1023);
          th = 0;
        end
        n_adv = 0;
        extra = $urandom_range(0, 3);
      end
      if (kind < 65 || (kind >= 80 && kind < 90))
        if ($urandom_range(0, 4) == 0) extra = $urandom_range(1, 2);
      send(cofr_pkg::OP_START, $urandom, $urandom, r, th, fm, $urandom);
      advance(n_adv + extra);
      items += 1 + n_adv;
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests: %0d outline and %0d fill circles started, %0d results checked",
             sb.n_requests, sb.n_outline, sb.n_fill, sb.n_results);
    $display("%0d circles ran to their final result, %0d mismatches",
             sb.n_closed, sb.n_bad);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cofr_pkg.sv
rtl/circle_outline_and_fill_raster_core.sv
dv/tb.sv
